>>> rtl/nv2argb_pkg.sv
// Shared types, constants and helper functions for the NV21 to ARGB pipeline.
package nv2argb_pkg;

  localparam int DIM_W = 13;
  localparam int CNT_W = 12;
  localparam int IDX_W = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
  localparam logic [DIM_W-1:0] WIDTH_RST = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  localparam logic [7:0] LUMA_OFS = 8'd16;
  localparam logic [7:0] CHROMA_FLIP = 8'h80;

  localparam logic [18:0] Y_GAIN = 19'd1192;
  localparam logic signed [20:0] RV_GAIN = 21'sd1634;
  localparam logic signed [20:0] GV_GAIN = 21'sd833;
  localparam logic signed [20:0] GU_GAIN = 21'sd400;
  localparam logic signed [20:0] BU_GAIN = 21'sd2066;
  localparam logic signed [21:0] CLAMP_MAX = 22'sd262143;

  localparam logic [7:0] RED_MIN = 8'd200;
  localparam logic [7:0] GB_MAX = 8'd100;
  localparam logic [31:0] ALPHA_OPAQUE = 32'hff000000;
  localparam logic [31:0] MAGENTA = 32'hffff00ff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // Item after the front stage: chroma resolved, position known.
  typedef struct packed {
    logic [7:0]       y;
    logic [7:0]       v;
    logic [7:0]       u;
    logic [CNT_W-1:0] col;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] rev_row;
    logic             frame_end;
  } s1_t;

  // Item after the product stage.
  typedef struct packed {
    logic [18:0]              y_term;
    logic signed [20:0]       rv;
    logic signed [20:0]       gv;
    logic signed [20:0]       gu;
    logic signed [20:0]       bu;
    logic [CNT_W+DIM_W-1:0]   col_h;
    logic [DIM_W-1:0]         rev_row;
    logic                     frame_end;
  } s2_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) res = 13'd1;
    else if (v > MAX_DIM) res = MAX_DIM;
    else res = v;
    return res;
  endfunction

  // Clamp to 18 bits and keep the top byte.
  function automatic logic [7:0] clamp_to_8(input logic signed [21:0] x);
    logic [7:0] res;
    if (x < 22'sd0) res = 8'd0;
    else if (x > CLAMP_MAX) res = 8'hff;
    else res = x[17:10];
    return res;
  endfunction

endpackage

>>> rtl/nv2argb_if.sv
// Pixel input and result channel interfaces.
interface nv2argb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_byte;
  logic [7:0] chroma_v;
  logic [7:0] chroma_u;

  modport source(output valid, luma_byte, chroma_v, chroma_u, input ready);
  modport sink(input valid, luma_byte, chroma_v, chroma_u, output ready);
endinterface

interface nv2argb_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;
  logic [23:0] dest_index;
  logic        frame_end;

  modport source(output valid, pixel_argb, dest_index, frame_end, input ready);
  modport sink(input valid, pixel_argb, dest_index, frame_end, output ready);
endinterface

>>> rtl/nv21_to_argb_rotate_recolor.sv
// Top level: NV21 pixel stream to recolored ARGB with rotated destination index.
//
//  port      dir  handshake      payload
//  in_pix    in   valid/ready    luma_byte[7:0], chroma_v[7:0], chroma_u[7:0]
//  out_res   out  valid/ready    pixel_argb[31:0], dest_index[23:0], frame_end
//  cfg_*     in   cfg_we         cfg_idx[1:0], cfg_data[12:0]
//
// One item per clock sustained while out_res.ready holds; three register stages (input,
// products, result) lie between an item being taken and its result.
// The depth is set by the coefficient multipliers and the col*height product.
// Synchronous active-low reset empties the pipe and restores 640x480.
// A stalled output fills empty stages first, then in_pix.ready drops.
module nv21_to_argb_rotate_recolor
  import nv2argb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  nv2argb_pix_if.sink          in_pix,
  nv2argb_res_if.source        out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic s1_valid, s1_ready, s2_valid, s2_ready;
  s1_t  s1;
  s2_t  s2;

  nv2argb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  nv2argb_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2)
  );

  nv2argb_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2),
    .out_res  (out_res)
  );

endmodule

>>> rtl/nv2argb_front.sv
// Front stage: frame size registers, column/row counters, chroma hold, input register.
module nv2argb_front
  import nv2argb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  nv2argb_pix_if.sink          in_pix,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DIM_W-1:0]     cfg_data,
  output logic                 s1_valid,
  input  logic                 s1_ready,
  output s1_t                  s1
);

  logic [DIM_W-1:0] w_r, h_r;
  logic [CNT_W-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [7:0]       held_v_r, held_u_r, v_nxt, u_nxt;
  logic             s1_valid_r;
  s1_t              s1_r, s1_nxt;
  logic             acc, last_col, last_row;

  assign in_pix.ready = !s1_valid_r || s1_ready;
  assign acc = in_pix.valid && in_pix.ready;
  assign s1_valid = s1_valid_r;
  assign s1 = s1_r;

  always_comb begin
    last_col = ({1'b0, col_r} + 13'd1) >= w_r;
    last_row = ({1'b0, row_r} + 13'd1) >= h_r;
    // chroma pair is latched on even columns only
    if (!col_r[0]) begin
      v_nxt = in_pix.chroma_v;
      u_nxt = in_pix.chroma_u;
    end else begin
      v_nxt = held_v_r;
      u_nxt = held_u_r;
    end
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + 12'd1;
    end else begin
      col_nxt = col_r + 12'd1;
      row_nxt = row_r;
    end
    s1_nxt.y = (in_pix.luma_byte < LUMA_OFS) ? 8'd0 : in_pix.luma_byte - LUMA_OFS;
    s1_nxt.v = v_nxt;
    s1_nxt.u = u_nxt;
    s1_nxt.col = col_r;
    s1_nxt.h = h_r;
    s1_nxt.rev_row = h_r - 13'd1 - {1'b0, row_r};
    s1_nxt.frame_end = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WIDTH_RST;
      h_r <= HEIGHT_RST;
      col_r <= '0;
      row_r <= '0;
      held_v_r <= '0;
      held_u_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_pix.ready) begin
        s1_valid_r <= in_pix.valid;
      end
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        held_v_r <= v_nxt;
        held_u_r <= u_nxt;
      end
      // a size write restarts the frame
      if (cfg_we) begin
        case (cfg_idx)
          REG_FRAME_WIDTH: begin
            w_r <= eff_dim(cfg_data);
            col_r <= '0;
            row_r <= '0;
          end
          REG_FRAME_HEIGHT: begin
            h_r <= eff_dim(cfg_data);
            col_r <= '0;
            row_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < w_r) else $error("column counter beyond frame width");
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_r} < h_r) else $error("row counter beyond frame height");
  a_odd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && col_r[0] |=> $stable(held_v_r) && $stable(held_u_r))
    else $error("held chroma changed on odd column");
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT)
    |=> col_r == '0 && row_r == '0)
    else $error("size write did not restart frame");

endmodule

>>> rtl/nv2argb_mul.sv
// Product stage: constant coefficient products and rotated-column product.
module nv2argb_mul
  import nv2argb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic s1_valid,
  output logic s1_ready,
  input  s1_t  s1,
  output logic s2_valid,
  input  logic s2_ready,
  output s2_t  s2
);

  logic              s2_valid_r;
  s2_t               s2_r, s2_nxt;
  logic signed [7:0] vs, us;

  assign s1_ready = !s2_valid_r || s2_ready;
  assign s2_valid = s2_valid_r;
  assign s2 = s2_r;

  always_comb begin
    // x - 128 for a byte is a flip of the top bit read as signed
    vs = signed'(s1.v ^ CHROMA_FLIP);
    us = signed'(s1.u ^ CHROMA_FLIP);
    s2_nxt.y_term = 19'(s1.y) * Y_GAIN;
    s2_nxt.rv = 21'(vs) * RV_GAIN;
    s2_nxt.gv = 21'(vs) * GV_GAIN;
    s2_nxt.gu = 21'(us) * GU_GAIN;
    s2_nxt.bu = 21'(us) * BU_GAIN;
    s2_nxt.col_h = (CNT_W+DIM_W)'(s1.col) * (CNT_W+DIM_W)'(s1.h);
    s2_nxt.rev_row = s1.rev_row;
    s2_nxt.frame_end = s1.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

>>> rtl/nv2argb_out.sv
// Output stage: channel sums, clamp, recolor, destination index, result register.
module nv2argb_out
  import nv2argb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s2_valid,
  output logic         s2_ready,
  input  s2_t          s2,
  nv2argb_res_if.source out_res
);

  logic               out_valid_r;
  logic [31:0]        argb_r, argb_nxt;
  logic [IDX_W-1:0]   dest_r, dest_nxt;
  logic               fend_r;
  logic signed [21:0] yt, r_sum, g_sum, b_sum;
  logic [7:0]         r8, g8, b8;

  assign s2_ready = !out_valid_r || out_res.ready;
  assign out_res.valid = out_valid_r;
  assign out_res.pixel_argb = argb_r;
  assign out_res.dest_index = dest_r;
  assign out_res.frame_end = fend_r;

  always_comb begin
    yt = signed'({3'b000, s2.y_term});
    r_sum = yt + 22'(s2.rv);
    g_sum = yt - 22'(s2.gv) - 22'(s2.gu);
    b_sum = yt + 22'(s2.bu);
    r8 = clamp_to_8(r_sum);
    g8 = clamp_to_8(g_sum);
    b8 = clamp_to_8(b_sum);
    // strongly red pixels are recolored
    if (r8 > RED_MIN && g8 < GB_MAX && b8 < GB_MAX) begin
      argb_nxt = MAGENTA;
    end else begin
      argb_nxt = ALPHA_OPAQUE | {8'h00, r8, g8, b8};
    end
    dest_nxt = IDX_W'(s2.col_h + (CNT_W+DIM_W)'(s2.rev_row));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      argb_r <= argb_nxt;
      dest_r <= dest_nxt;
      fend_r <= s2.frame_end;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the NV21 to ARGB rotate/recolor pixel pipeline.
module tb;
  import nv2argb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int RAND_ITEMS = 530;
  localparam int LONG_HOLD = 90;
  localparam int HOLD_PHASE = 2;
  localparam logic [7:0] EDGE_BYTES [0:4] = '{8'd0, 8'd255, 8'd15, 8'd16, 8'd128};
  localparam int IDLE_PCTS [0:2] = '{0, 20, 50};

  typedef struct packed {
    logic [31:0] argb;
    logic [23:0] dest;
    logic        fend;
  } pix_result_t;

  typedef enum logic { ROW_PIXEL, ROW_WRITE } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     data;
    logic [7:0]           y;
    logic [7:0]           v;
    logic [7:0]           u;
    logic                 typed;
    pix_result_t          res;
  } dir_row_t;

  // typed results only where they follow directly from reset or the size extremes
  localparam dir_row_t DIRECTED [0:29] = '{
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd16, 8'd128, 8'd128, 1'b1,
      '{32'hff000000, 24'd479, 1'b0}},
    // odd column: chroma inputs ignored, held pair reused
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd255, 8'd0, 8'd0, 1'b1,
      '{32'hffffffff, 24'd959, 1'b0}},
    '{ROW_WRITE, REG_FRAME_WIDTH, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    // 1x1 frame: every pixel ends a frame
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd0, 8'd255, 8'd255, 1'b1,
      '{32'hffca00ff, 24'd0, 1'b1}},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd16, 8'd255, 8'd128, 1'b1,
      '{32'hffff00ff, 24'd0, 1'b1}},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd255, 8'd0, 8'd0, 1'b1,
      '{32'hff49ff13, 24'd0, 1'b1}},
    '{ROW_WRITE, REG_FRAME_WIDTH, 13'd8191, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'd4096, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd128, 8'd200, 8'd60, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd90, 8'd0, 8'd255, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd200, 8'd60, 8'd250, 1'b0, '0},
    // unlisted index: no effect, counters keep running
    '{ROW_WRITE, REG_SPARE_2, 13'h1555, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd1, 8'd127, 8'd129, 1'b0, '0},
    '{ROW_WRITE, REG_SPARE_3, 13'h0aaa, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd17, 8'd128, 8'd255, 1'b0, '0},
    // odd width: chroma relatched at each row start
    '{ROW_WRITE, REG_FRAME_WIDTH, 13'd3, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'd2, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd235, 8'd240, 8'd16, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd100, 8'd1, 8'd1, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd50, 8'd250, 8'd110, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd255, 8'd128, 8'd128, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd15, 8'd90, 8'd200, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd180, 8'd30, 8'd230, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd64, 8'd255, 8'd255, 1'b0, '0},
    '{ROW_WRITE, REG_FRAME_WIDTH, 13'd2, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'd4097, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd16, 8'd16, 8'd240, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd240, 8'd240, 8'd16, 1'b0, '0},
    '{ROW_PIXEL, REG_FRAME_WIDTH, 13'd0, 8'd128, 8'd128, 8'd128, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DIM_W-1:0] cfg_data;

  nv2argb_pix_if in_pix ();
  nv2argb_res_if out_res ();

  nv21_to_argb_rotate_recolor u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [CNT_W-1:0] col_q;
  logic [CNT_W-1:0] row_q;
  logic [7:0] hold_v;
  logic [7:0] hold_u;

  pix_result_t pending_pixels [$];
  int mismatch_count = 0;
  int pixels_sent = 0;
  int directed_pixels = 0;
  int reg_writes = 0;
  int results_seen = 0;
  int frame_ends = 0;
  int recolored = 0;
  int tx_idle_pct = 30;
  int rx_idle_pct = 30;
  bit hold_req = 1'b0;
  bit rx_hold = 1'b0;

  function automatic int clip_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return 1;
    if (d > 13'd4096) return 4096;
    return int'(d);
  endfunction

  function automatic logic [7:0] to_chan(input int x);
    logic [31:0] t;
    if (x < 0) t = '0;
    else if (x > 262143) t = 32'd262143;
    else t = x;
    return t[17:10];
  endfunction

  function automatic pix_result_t predict_pixel(input logic [7:0] y_in, v_in, u_in);
    int w, h, luma, cv, cu, ly, dest;
    logic [7:0] r8, g8, b8;
    logic last_col, last_row;
    pix_result_t res;
    w = clip_dim(width_reg);
    h = clip_dim(height_reg);
    if (!col_q[0]) begin
      hold_v = v_in;
      hold_u = u_in;
    end
    luma = int'(y_in) - 16;
    if (luma < 0) luma = 0;
    cv = int'(hold_v) - 128;
    cu = int'(hold_u) - 128;
    ly = 1192 * luma;
    r8 = to_chan(ly + 1634 * cv);
    g8 = to_chan(ly - 833 * cv - 400 * cu);
    b8 = to_chan(ly + 2066 * cu);
    if (r8 > 8'd200 && g8 < 8'd100 && b8 < 8'd100) res.argb = 32'hffff00ff;
    else res.argb = {8'hff, r8, g8, b8};
    dest = int'(col_q) * h + (h - 1 - int'(row_q));
    res.dest = dest[23:0];
    last_col = (int'(col_q) + 1 >= w);
    last_row = (int'(row_q) + 1 >= h);
    res.fend = last_col && last_row;
    if (last_col) begin
      col_q = '0;
      row_q = last_row ? '0 : row_q + CNT_W'(1);
    end else begin
      col_q = col_q + CNT_W'(1);
    end
    return res;
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // sizes change only with the pipe drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    in_pix.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
      if (idx == REG_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
      col_q = '0;
      row_q = '0;
    end
  endtask

  // leaves valid high; caller either sends again or drops it
  task automatic send_pixel(input logic [7:0] y, v, u, input logic typed,
                            input pix_result_t typed_res);
    int gap;
    pix_result_t pred;
    gap = rx_hold ? 0 : pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.luma_byte <= y;
    in_pix.chroma_v <= v;
    in_pix.chroma_u <= u;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    pred = predict_pixel(y, v, u);
    pending_pixels.push_back(typed ? typed_res : pred);
    pixels_sent++;
  endtask

  // result side: check, then pick next ready
  initial begin
    pix_result_t want;
    int stall_left;
    stall_left = 0;
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_res.valid && out_res.ready) begin
        results_seen++;
        if (out_res.frame_end) frame_ends++;
        if (out_res.pixel_argb == 32'hffff00ff) recolored++;
        if (pending_pixels.size() == 0) begin
          flag_mismatch("result with nothing pending", out_res.pixel_argb, '0);
        end else begin
          want = pending_pixels.pop_front();
          if (out_res.pixel_argb !== want.argb)
            flag_mismatch("pixel_argb", out_res.pixel_argb, want.argb);
          if (out_res.dest_index !== want.dest)
            flag_mismatch("dest_index", 32'(out_res.dest_index), 32'(want.dest));
          if (out_res.frame_end !== want.fend)
            flag_mismatch("frame_end", 32'(out_res.frame_end), 32'(want.fend));
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        rx_hold = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left == 0) begin
        rx_hold = 1'b0;
        stall_left = pick_gap(rx_idle_pct);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  initial begin
    int phase, n_items, rand_items, w, h;
    logic [7:0] py, pv, pu;
    in_pix.valid = 1'b0;
    in_pix.luma_byte = '0;
    in_pix.chroma_v = '0;
    in_pix.chroma_u = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_FRAME_WIDTH;
    cfg_data = '0;
    rst_n = 1'b0;
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    col_q = '0;
    row_q = '0;
    hold_v = '0;
    hold_u = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        send_pixel(DIRECTED[i].y, DIRECTED[i].v, DIRECTED[i].u,
                   DIRECTED[i].typed, DIRECTED[i].res);
        directed_pixels++;
      end
    end

    phase = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(9))
        6: begin
          w = 0;
          h = $urandom_range(4);
        end
        7: begin
          w = $urandom_range(8191, 4096);
          h = $urandom_range(3, 1);
        end
        8: begin
          w = $urandom_range(4, 1);
          h = $urandom_range(8191, 4090);
        end
        9: begin
          w = $urandom_range(8191);
          h = $urandom_range(8191);
        end
        default: begin
          w = $urandom_range(8, 1);
          h = $urandom_range(6, 1);
        end
      endcase
      // sometimes keep the running frame and only poke an unlisted index
      if ($urandom_range(4) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                  DIM_W'($urandom_range(8191)));
      end else if ($urandom_range(1)) begin
        write_reg(REG_FRAME_WIDTH, DIM_W'(w));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(h));
      end else begin
        write_reg(REG_FRAME_HEIGHT, DIM_W'(h));
        write_reg(REG_FRAME_WIDTH, DIM_W'(w));
      end
      tx_idle_pct = IDLE_PCTS[$urandom_range(2)];
      rx_idle_pct = IDLE_PCTS[$urandom_range(2)];
      n_items = $urandom_range(40, 10);
      if (phase == HOLD_PHASE) begin
        n_items = 60;
        tx_idle_pct = 0;
      end
      for (int k = 0; k < n_items; k++) begin
        if (phase == HOLD_PHASE && k == 8) hold_req = 1'b1;
        case ($urandom_range(7))
          0, 1: begin
            // red-heavy area around the recolor threshold
            py = 8'($urandom_range(120, 30));
            pv = 8'($urandom_range(255, 190));
            pu = 8'($urandom_range(170, 90));
          end
          2: begin
            py = EDGE_BYTES[$urandom_range(4)];
            pv = EDGE_BYTES[$urandom_range(4)];
            pu = EDGE_BYTES[$urandom_range(4)];
          end
          default: begin
            py = 8'($urandom_range(255));
            pv = 8'($urandom_range(255));
            pu = 8'($urandom_range(255));
          end
        endcase
        send_pixel(py, pv, pu, 1'b0, '0);
        rand_items++;
      end
      phase++;
    end

    in_pix.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("run covered %0d pixels (%0d directed) over %0d size phases, %0d register writes",
             pixels_sent, directed_pixels, phase, reg_writes);
    $display("results checked %0d, frame ends %0d, recolored pixels %0d, mismatches %0d",
             results_seen, frame_ends, recolored, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", pending_pixels.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
rtl/nv2argb_pkg.sv
rtl/nv2argb_if.sv
rtl/nv2argb_front.sv
rtl/nv2argb_mul.sv
rtl/nv2argb_out.sv
rtl/nv21_to_argb_rotate_recolor.sv
tb/tb.sv
